// File: rtl/pgm_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// pgm_pkg
// Shared constants and types of the palette gradient mapper.
// ----------------------------------------------------------------------------
package pgm_pkg;

	localparam int PALETTE_DEPTH = 16;
	localparam int FRAC_BITS     = 16;

	localparam int IDX_W  = $clog2(PALETTE_DEPTH);
	localparam int CNT_W  = 5;
	localparam int CHAN_W = 8;
	localparam int RGB_W  = 3 * CHAN_W;
	localparam int MAG_W  = FRAC_BITS + 2;
	localparam int M_W    = FRAC_BITS + 1;
	localparam int S_W    = M_W + CNT_W;
	localparam int UP_W   = S_W - FRAC_BITS + 1;
	localparam int DIFF_W = CHAN_W + 1;
	localparam int PROD_W = DIFF_W + M_W + 1;

	localparam logic [M_W-1:0] ONE_FX  = M_W'(1) << FRAC_BITS;
	localparam logic [M_W-1:0] HALF_FX = M_W'(1) << (FRAC_BITS - 1);

	localparam logic [CNT_W-1:0] NUM_COLORS_RESET = CNT_W'(5);
	localparam logic [CNT_W-1:0] MIN_COLORS       = CNT_W'(2);
	localparam logic [CNT_W-1:0] MAX_COLORS       = CNT_W'(PALETTE_DEPTH);

	localparam logic CMD_WRITE = 1'b0;
	localparam logic CMD_MAP   = 1'b1;

	localparam logic [0:0] REG_NUM_COLORS  = 1'b0;
	localparam logic [0:0] REG_CYCLIC_MODE = 1'b1;

	typedef logic [2:0][CHAN_W-1:0] rgb_t;

endpackage
`default_nettype wire

// File: rtl/pgm_ram.sv
`default_nettype none
// ----------------------------------------------------------------------------
// pgm_ram
// Generic RAM with one write port and one registered read port.
// ----------------------------------------------------------------------------
module pgm_ram #(
	parameter int WIDTH = 24,
	parameter int DEPTH = 16
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule
`default_nettype wire

// File: rtl/palette_gradient_mapper_top.sv
`default_nettype none
// ----------------------------------------------------------------------------
// palette_gradient_mapper_top
// Maps a signed Q2.16 magnitude to an RGB color by linear interpolation between
// entries of a 16-entry palette.
// ----------------------------------------------------------------------------
// The block takes one transfer per clock while the output is not stalled.
// A map transfer passes through clamp and fold, scale by the color count,
// palette read, channel multiply, and the output register. Palette
// write transfers (tuser 0) produce no output and take effect in order with
// the map transfers around them. The whole pipeline holds while the output is
// stalled. Palette entries must be written before a map transfer uses them.
// ----------------------------------------------------------------------------
module palette_gradient_mapper_top (
	input  wire logic        clk,
	input  wire logic        arst_n,
	// Configuration write port.
	input  wire logic        cfg_we,
	input  wire logic [0:0]  cfg_index,
	input  wire logic [4:0]  cfg_data,
	// Input stream.
	input  wire logic        s_tvalid,
	output logic             s_tready,
	// tdata: entry_index[3:0], entry_red[11:4], entry_green[19:12],
	// entry_blue[27:20], magnitude[45:28], zero padding[47:46].
	input  wire logic [47:0] s_tdata,
	// tuser: cmd.
	input  wire logic        s_tuser,
	// Output stream.
	output logic             m_tvalid,
	input  wire logic        m_tready,
	// tdata: red_out[7:0], green_out[15:8], blue_out[23:16].
	output logic [23:0]      m_tdata
);

	localparam int IDX_W  = pgm_pkg::IDX_W;
	localparam int CNT_W  = pgm_pkg::CNT_W;
	localparam int CHAN_W = pgm_pkg::CHAN_W;
	localparam int RGB_W  = pgm_pkg::RGB_W;
	localparam int MAG_W  = pgm_pkg::MAG_W;
	localparam int M_W    = pgm_pkg::M_W;
	localparam int S_W    = pgm_pkg::S_W;
	localparam int UP_W   = pgm_pkg::UP_W;
	localparam int DIFF_W = pgm_pkg::DIFF_W;
	localparam int PROD_W = pgm_pkg::PROD_W;
	localparam int FRAC_BITS = pgm_pkg::FRAC_BITS;

	// Configuration registers.
	logic [CNT_W-1:0] num_colors_q;
	logic             cyclic_mode_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			num_colors_q  <= pgm_pkg::NUM_COLORS_RESET;
			cyclic_mode_q <= 1'b0;
		end else if (cfg_we) begin
			case (cfg_index)
				pgm_pkg::REG_NUM_COLORS:  num_colors_q  <= cfg_data;
				pgm_pkg::REG_CYCLIC_MODE: cyclic_mode_q <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// Input field split.
	logic [IDX_W-1:0]  in_index;
	pgm_pkg::rgb_t     in_rgb;
	logic [MAG_W-1:0]  in_mag;

	assign in_index  = IDX_W'(s_tdata[3:0]);
	assign in_rgb[2] = s_tdata[11:4];
	assign in_rgb[1] = s_tdata[19:12];
	assign in_rgb[0] = s_tdata[27:20];
	assign in_mag    = s_tdata[45:28];

	logic en;
	logic out_valid_q;

	assign en       = !out_valid_q || m_tready;
	assign s_tready = en;

	// Stage 1 input: clamp, fold and color count clamp.
	logic [M_W-1:0]   m_clamp;
	logic [M_W-1:0]   m_fold;
	logic [CNT_W-1:0] n_clamp;

	always_comb begin
		if (in_mag[MAG_W-1]) begin
			m_clamp = '0;
		end else if (in_mag[M_W-1:0] > pgm_pkg::ONE_FX) begin
			m_clamp = pgm_pkg::ONE_FX;
		end else begin
			m_clamp = in_mag[M_W-1:0];
		end
		if (cyclic_mode_q && (m_clamp > pgm_pkg::HALF_FX)) begin
			m_fold = pgm_pkg::ONE_FX - m_clamp;
		end else begin
			m_fold = m_clamp;
		end
		if (num_colors_q < pgm_pkg::MIN_COLORS) begin
			n_clamp = pgm_pkg::MIN_COLORS;
		end else if (num_colors_q > pgm_pkg::MAX_COLORS) begin
			n_clamp = pgm_pkg::MAX_COLORS;
		end else begin
			n_clamp = num_colors_q;
		end
	end

	logic             v_s1;
	logic             cmd_s1;
	logic [IDX_W-1:0] index_s1;
	logic [RGB_W-1:0] wdata_s1;
	logic [M_W-1:0]   m_s1;
	logic [CNT_W-1:0] n_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (en) begin
			v_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			cmd_s1   <= s_tuser;
			index_s1 <= in_index;
			wdata_s1 <= in_rgb;
			m_s1     <= m_fold;
			n_s1     <= n_clamp;
		end
	end

	// Stage 2: scaled value.
	logic             v_s2;
	logic             cmd_s2;
	logic [IDX_W-1:0] index_s2;
	logic [RGB_W-1:0] wdata_s2;
	logic [S_W-1:0]   s_s2;
	logic [CNT_W-1:0] n_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (en) begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			cmd_s2   <= cmd_s1;
			index_s2 <= index_s1;
			wdata_s2 <= wdata_s1;
			s_s2     <= S_W'(m_s1) * S_W'(n_s1);
			n_s2     <= n_s1;
		end
	end

	// Segment selection and palette access.
	logic [S_W:0]     s_round;
	logic [UP_W-1:0]  upper;
	logic [IDX_W-1:0] lower_idx;
	logic [IDX_W-1:0] upper_idx;
	logic [S_W-1:0]   base;
	logic [S_W-1:0]   frac_full;
	logic             pal_we;

	always_comb begin
		s_round = (S_W + 1)'(s_s2) + (S_W + 1)'(pgm_pkg::ONE_FX - M_W'(1));
		upper   = UP_W'(s_round[S_W:FRAC_BITS]);
		if (upper == '0) begin
			upper = UP_W'(1);
		end
		lower_idx = IDX_W'(upper - UP_W'(1));
		if (upper >= UP_W'(n_s2)) begin
			upper_idx = '0;
		end else begin
			upper_idx = IDX_W'(upper);
		end
		base      = S_W'(lower_idx) << FRAC_BITS;
		frac_full = s_s2 - base;
	end

	assign pal_we = en && v_s2 && (cmd_s2 == pgm_pkg::CMD_WRITE);

	logic [RGB_W-1:0] lo_rd;
	logic [RGB_W-1:0] hi_rd;

	pgm_ram #(
		.WIDTH(RGB_W),
		.DEPTH(pgm_pkg::PALETTE_DEPTH)
	) u_ram_lo (
		.clk   (clk),
		.we    (pal_we),
		.waddr (index_s2),
		.wdata (wdata_s2),
		.re    (en),
		.raddr (lower_idx),
		.rdata (lo_rd)
	);

	pgm_ram #(
		.WIDTH(RGB_W),
		.DEPTH(pgm_pkg::PALETTE_DEPTH)
	) u_ram_hi (
		.clk   (clk),
		.we    (pal_we),
		.waddr (index_s2),
		.wdata (wdata_s2),
		.re    (en),
		.raddr (upper_idx),
		.rdata (hi_rd)
	);

	// Stage 3: palette data and fraction.
	logic           v_s3;
	logic [M_W-1:0] frac_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
		end else if (en) begin
			v_s3 <= v_s2 && (cmd_s2 == pgm_pkg::CMD_MAP);
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			frac_s3 <= M_W'(frac_full);
		end
	end

	pgm_pkg::rgb_t lo_rgb;
	pgm_pkg::rgb_t hi_rgb;
	logic signed [PROD_W-1:0] prod [3];

	assign lo_rgb = lo_rd;
	assign hi_rgb = hi_rd;

	always_comb begin
		logic signed [DIFF_W-1:0] diff;
		logic signed [M_W:0]      frac_sg;
		frac_sg = $signed({1'b0, frac_s3});
		for (int c = 0; c < 3; c++) begin
			diff    = $signed({1'b0, hi_rgb[c]}) - $signed({1'b0, lo_rgb[c]});
			prod[c] = PROD_W'(diff) * PROD_W'(frac_sg);
		end
	end

	// Stage 4: products.
	logic                     v_s4;
	pgm_pkg::rgb_t            lo_s4;
	logic signed [PROD_W-1:0] prod_s4 [3];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s4 <= 1'b0;
		end else if (en) begin
			v_s4 <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			lo_s4 <= lo_rgb;
			for (int c = 0; c < 3; c++) begin
				prod_s4[c] <= prod[c];
			end
		end
	end

	pgm_pkg::rgb_t blend;

	always_comb begin
		logic [PROD_W-1:0] acc;
		for (int c = 0; c < 3; c++) begin
			acc      = PROD_W'(lo_s4[c]) + PROD_W'(prod_s4[c] >>> FRAC_BITS);
			blend[c] = acc[CHAN_W-1:0];
		end
	end

	// Output register.
	pgm_pkg::rgb_t rgb_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (en) begin
			out_valid_q <= v_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rgb_q <= blend;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {rgb_q[0], rgb_q[1], rgb_q[2]};

endmodule
`default_nettype wire
